// ===== rtl/core/tkst_pkg.sv =====
// Shared constants for the top-K stream tracker.
package tkst_pkg;

  // Default number of held values.
  localparam int TOP_K_DEF = 3;

  // Width of one value word.
  localparam int WORD_W = 32;

  // Input operation codes.
  localparam logic OP_OFFER  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

endpackage

// ===== rtl/core/top_k_stream_tracker_top.sv =====
// Top-K stream tracker: min-heap of the largest values in one synchronous memory.
//
// Holds the TOP_K largest signed 32-bit values offered so far in a binary
// min-heap kept in a memory with one read port, one write port and a
// registered read. One input word is taken at a time. An offer not above the
// root of a full heap is dropped; one into an empty heap goes straight to
// the place step. While the heap fills, an offer reads and compares each
// parent it may move past, then places the value. Once the heap is full, a
// replacement reads the left child, reads the right child and compares for
// each level whose children are compared, takes one more step when the hole
// reaches a leaf, and then places the value. For each result word of a
// report, the n held values are read, one compare step follows and the word
// is handed over when the output is not stalled. An empty report gives one
// word flagged empty. The next input word is taken in the cycle after the
// last result word of a report leaves. No clearing pass is needed after
// reset.
module top_k_stream_tracker_top
  import tkst_pkg::*;
#(
  parameter int TOP_K = TOP_K_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     op,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] item,
  output logic                     empty_res,
  output logic                     last
);

  // Address, count and child-index widths.
  localparam int AW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int CW = $clog2(TOP_K + 1);
  localparam int IW = ((AW + 2) > CW) ? (AW + 2) : CW;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_UP_RD  = 10'b00_0000_0010,
    S_UP_CMP = 10'b00_0000_0100,
    S_DN_L   = 10'b00_0000_1000,
    S_DN_R   = 10'b00_0001_0000,
    S_DN_CMP = 10'b00_0010_0000,
    S_FIN    = 10'b00_0100_0000,
    S_SCAN   = 10'b00_1000_0000,
    S_TAIL   = 10'b01_0000_0000,
    S_OUT    = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Heap memory and its ports.
  logic signed [WORD_W-1:0] heap_mem [TOP_K];
  logic signed [WORD_W-1:0] rdata;
  logic        [AW-1:0]     raddr;
  logic                     we;
  logic        [AW-1:0]     waddr;
  logic signed [WORD_W-1:0] wdata;

  // Heap control.
  logic        [CW-1:0]     count;
  logic signed [WORD_W-1:0] root;
  logic        [AW-1:0]     pos;
  logic signed [WORD_W-1:0] cur;
  logic signed [WORD_W-1:0] ldata;

  // Report scan.
  logic        [AW-1:0]     scan_idx;
  logic                     cmp_v;
  logic        [AW-1:0]     cmp_idx;
  logic signed [WORD_W-1:0] best_val;
  logic        [AW-1:0]     best_idx;
  logic                     best_valid;
  logic signed [WORD_W-1:0] prev_val;
  logic        [AW-1:0]     prev_idx;
  logic                     have_prev;
  logic        [CW-1:0]     rank;
  logic                     empty_q;

  // Derived indexes.
  logic [AW-1:0] parent_idx;
  logic [IW-1:0] left_w;
  logic [IW-1:0] right_w;
  logic          left_ok;
  logic          right_ok;
  logic          pick_right;
  logic signed [WORD_W-1:0] child_val;
  logic [AW-1:0] child_idx;
  logic          cand;
  logic          in_acc;
  logic          out_acc;
  logic          last_word;

  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid && !out_stall;
  assign parent_idx = (pos - AW'(1)) >> 1;
  assign left_w     = IW'({pos, 1'b1});
  assign right_w    = left_w + IW'(1);
  assign left_ok    = left_w < IW'(count);
  assign right_ok   = right_w < IW'(count);
  assign pick_right = right_ok && (rdata < ldata);
  assign child_val  = pick_right ? rdata : ldata;
  assign child_idx  = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];

  // Entry is above the previous result (tie: higher index), below the best so far.
  assign cand = (!have_prev || (rdata > prev_val) ||
                 ((rdata == prev_val) && (cmp_idx > prev_idx))) &&
                (!best_valid || (rdata < best_val));

  assign last_word = empty_q || ((rank + CW'(1)) == count);

  // Outputs.
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign item      = best_val;
  assign empty_res = empty_q;
  assign last      = last_word;

  // Memory read address per state.
  always_comb begin
    unique case (state)
      S_UP_RD: raddr = parent_idx;
      S_DN_L:  raddr = left_w[AW-1:0];
      S_DN_R:  raddr = right_w[AW-1:0];
      S_SCAN:  raddr = scan_idx;
      default: raddr = pos;
    endcase
  end

  // Memory write: move a child or parent into the hole, or place the carried value.
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = cur;
    unique case (state)
      S_UP_CMP: begin
        if (cur < rdata) begin
          we    = 1'b1;
          wdata = rdata;
        end
      end
      S_DN_CMP: begin
        if (child_val < cur) begin
          we    = 1'b1;
          wdata = child_val;
        end
      end
      S_FIN: begin
        we = 1'b1;
      end
      default: ;
    endcase
  end

  // Synchronous memory.
  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    rdata <= heap_mem[raddr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (op == OP_REPORT) begin
            state_next = (count == '0) ? S_OUT : S_SCAN;
          end else if (count < CW'(TOP_K)) begin
            state_next = (count == '0) ? S_FIN : S_UP_RD;
          end else if (value > root) begin
            state_next = S_DN_L;
          end
        end
      end
      S_UP_RD:  state_next = S_UP_CMP;
      S_UP_CMP: begin
        if ((cur < rdata) && (parent_idx != '0)) begin
          state_next = S_UP_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DN_L:   state_next = left_ok ? S_DN_R : S_FIN;
      S_DN_R:   state_next = S_DN_CMP;
      S_DN_CMP: state_next = (child_val < cur) ? S_DN_L : S_FIN;
      S_FIN:    state_next = S_IDLE;
      S_SCAN: begin
        if (CW'(scan_idx) + CW'(1) == count) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL:   state_next = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_next = last_word ? S_IDLE : S_SCAN;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cmp_v <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_acc && op == OP_OFFER && count < CW'(TOP_K)) begin
        count <= count + CW'(1);
      end
      cmp_v <= (state == S_SCAN);
    end
  end

  // Heap datapath: carry the value and track the hole.
  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      root <= wdata;
    end
    unique case (state)
      S_IDLE: begin
        cur <= value;
        pos <= (count < CW'(TOP_K)) ? count[AW-1:0] : '0;
      end
      S_UP_CMP: begin
        if (cur < rdata) begin
          pos <= parent_idx;
        end
      end
      S_DN_R: begin
        ldata <= rdata;
      end
      S_DN_CMP: begin
        if (child_val < cur) begin
          pos <= child_idx;
        end
      end
      default: ;
    endcase
  end

  // Report datapath: select the next value in ascending order.
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (cmp_v && cand) begin
      best_val   <= rdata;
      best_idx   <= cmp_idx;
      best_valid <= 1'b1;
    end
    unique case (state)
      S_IDLE: begin
        scan_idx   <= '0;
        best_valid <= 1'b0;
        have_prev  <= 1'b0;
        rank       <= '0;
        empty_q    <= (count == '0);
        best_val   <= '0;
      end
      S_SCAN: begin
        scan_idx <= scan_idx + AW'(1);
      end
      S_OUT: begin
        if (out_acc) begin
          prev_val   <= best_val;
          prev_idx   <= best_idx;
          have_prev  <= 1'b1;
          rank       <= rank + CW'(1);
          scan_idx   <= '0;
          best_valid <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TOP_K))
    else $error("held count above capacity");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> last && (count == '0))
    else $error("empty result not final or set not empty");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !in_stall)
    else $error("input not released after final result word");

  a_report_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op == OP_REPORT) |=> in_stall)
    else $error("report did not hold off input");

  a_no_out_offer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op == OP_OFFER) |=> !out_valid)
    else $error("offer produced a result word");

endmodule

// ===== verif/top_k_stream_tracker_top_test.sv =====
// Testbench for the top-K stream tracker: random-gap stimulus with a self-checking scoreboard.
module top_k_stream_tracker_top_test;
  import tkst_pkg::*;

  localparam int HELD_MAX   = TOP_K_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_WORDS = 80;
  localparam int DRAIN_WAIT = 30;
  localparam int HOLD_LEN   = 300;

  // One result word as the block should present it
  typedef struct packed {
    logic signed [WORD_W-1:0] item;
    logic                     empty_res;
    logic                     last;
  } report_word_t;

  // Predicts the held top set and checks report words against it
  class top_set_board;
    logic signed [WORD_W-1:0] held[$];
    report_word_t             due_words[$];
    int                       errors;
    int                       checked;
    int                       reports;

    // Insert keeping the held set in ascending order
    function void place(logic signed [WORD_W-1:0] v);
      int idx;
      idx = 0;
      while (idx < held.size() && held[idx] <= v) idx++;
      held.insert(idx, v);
    endfunction

    // Note an accepted input word and queue the words it should produce
    function void take_word(logic o, logic signed [WORD_W-1:0] v);
      report_word_t w;
      if (o == OP_OFFER) begin
        if (held.size() < HELD_MAX) begin
          place(v);
        end else if (v > held[0]) begin
          held.delete(0);
          place(v);
        end
      end else begin
        reports++;
        if (held.size() == 0) begin
          w.item      = '0;
          w.empty_res = 1'b1;
          w.last      = 1'b1;
          due_words   = {due_words, w};
        end else begin
          for (int i = 0; i < held.size(); i++) begin
            w.item      = held[i];
            w.empty_res = 1'b0;
            w.last      = (i == held.size() - 1);
            due_words   = {due_words, w};
          end
        end
      end
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_result(logic signed [WORD_W-1:0] it, logic em, logic la);
      report_word_t w;
      checked++;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected result word: item %0d empty_res %0b last %0b",
                 $time, it, em, la);
        errors++;
      end else begin
        w = due_words.pop_front();
        if (it !== w.item) begin
          $display("%0t: item mismatch: expected %0d, got %0d", $time, w.item, it);
          errors++;
        end
        if (em !== w.empty_res) begin
          $display("%0t: empty_res mismatch: expected %0b, got %0b", $time, w.empty_res, em);
          errors++;
        end
        if (la !== w.last) begin
          $display("%0t: last mismatch: expected %0b, got %0b", $time, w.last, la);
          errors++;
        end
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic                     op;
  logic signed [WORD_W-1:0] value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [WORD_W-1:0] item;
  logic                     empty_res;
  logic                     last;

  top_set_board sb = new();
  int           words_in;
  int           idle_cycles;
  bit           hold_done;

  top_k_stream_tracker_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .item      (item),
    .empty_res (empty_res),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one word and hold it until the block takes it
  task automatic send_word(input logic o, input logic signed [WORD_W-1:0] v);
    in_valid <= 1'b1;
    op       <= o;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_word(o, v);
    words_in++;
  endtask

  // Drop valid for a random stretch, mostly short, now and then long
  task automatic sender_gap();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      n = 0;
    end else if (pick < 9) begin
      n = $urandom_range(1, 3);
    end else begin
      n = $urandom_range(10, 30);
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic offer_gap(input logic signed [WORD_W-1:0] v);
    send_word(OP_OFFER, v);
    sender_gap();
  endtask

  task automatic report_gap();
    send_word(OP_REPORT, $urandom);
    sender_gap();
  endtask

  // Main stimulus
  initial begin
    int                       pick;
    logic signed [WORD_W-1:0] v;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    op       <= OP_OFFER;
    value    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty report, partial set, extremes, equal and smaller values
    report_gap();
    offer_gap(32'sh7FFF_FFFF);
    report_gap();
    offer_gap(32'sh8000_0000);
    report_gap();
    offer_gap(-32'sd1);
    report_gap();
    offer_gap(32'sh8000_0000);
    report_gap();
    offer_gap(32'sd5);
    report_gap();
    offer_gap(32'sd5);
    report_gap();
    offer_gap(32'sd5);
    offer_gap(-32'sd1);
    report_gap();
    offer_gap(32'sh7FFF_FFFF);
    report_gap();

    // Random: a rising stream so that replacements keep happening
    for (int i = 0; i < RAND_WORDS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        report_gap();
      end else begin
        if (pick < 80) begin
          v = 32'sh7FF0_0000 + i * 8 + int'($urandom_range(0, 60)) - 30;
        end else if (pick < 90) begin
          v = $urandom | 32'h8000_0000;
        end else begin
          v = (sb.held.size() > 0) ? sb.held[0] : $urandom;
        end
        offer_gap(v);
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding reports, then allow stray words to show up
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d input words, %0d of them reports, %0d result words checked",
             words_in, sb.reports, sb.checked);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: random stalls plus one long hold-off to back the block up
  initial begin
    int pick;
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && words_in >= 40) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 20);
        end else if (pick < 9) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(10, 40);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  // Check each result word as it is taken
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(item, empty_res, last);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/tkst_pkg.sv
rtl/core/top_k_stream_tracker_top.sv
verif/top_k_stream_tracker_top_test.sv
